// File: sv/assert_macros.svh
// Assertion macros for the port-level checker file of the time client block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is asserted
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same check with the standard clocking, antecedent and consequent split out
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/sntp_pkg.sv
// Package for the time client controller: types, codes, constants, helpers.
// No dependencies; design files use scoped names, test files import it.
`default_nettype none

package sntp_pkg;

    // Counter width of the retry, request and report counters
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int REG_W  = 16;
    localparam int IDX_W  = 3;

    // Seconds from 1900 to 1970
    localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
    localparam logic [15:0] MIN_LENGTH   = 16'd48;
    localparam logic [7:0]  MAX_STRATUM  = 8'd15;
    localparam logic [2:0]  NTP_MODE_SERVER = 3'd4;
    localparam logic [1:0]  LEAP_ALARM   = 2'b11;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_RETRY   = 3'd0,
        REG_RESYNC  = 3'd1,
        REG_TIMEOUT = 3'd2,
        REG_REPORT  = 3'd3,
        REG_PORT    = 3'd4
    } t_reg_idx;

    // Kind of input word
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_REPLY = 2'd1,
        MODE_FAIL  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PENDING  = 2'd1,
        PH_RECEIVED = 2'd2,
        PH_FAILED   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [REG_W-1:0] retry_interval;
        logic [REG_W-1:0] resync_interval;
        logic [REG_W-1:0] request_timeout;
        logic [REG_W-1:0] report_interval;
        logic [REG_W-1:0] server_port;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        network_ready;
        logic        rtc_write_ok;
        logic        start_ok;
        logic        rtc_synchronized;
        logic        reply_present;
        logic [15:0] source_port;
        logic [15:0] reply_length;
        logic [7:0]  header_flags;
        logic [7:0]  stratum;
        logic [31:0] transmit_seconds;
    } t_item;

    // Reply check outcome passed to the state logic
    typedef struct packed {
        logic        ok;
        logic [31:0] unix_time;
    } t_reply;

    typedef struct packed {
        logic [1:0]  sync_state;
        logic        start_request;
        logic        set_time;
        logic [31:0] unix_time;
        logic        report_time;
        logic        network_wait_notice;
        logic        failure_notice;
        logic        synced_notice;
    } t_result;

    // Register value limited to the largest counter value
    function automatic logic [CNT_W-1:0] clip_cnt(input logic [REG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return CNT_W'(w);
    endfunction

    // Saturating increment
    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        if (v == CNT_MAX) begin
            return v;
        end
        return v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: sv/sntp_sync_controller.sv
// Top level of the time client controller: stream ports, input and result registers.
// Depends on sntp_pkg, sntp_cfg_regs, sntp_reply_check and sntp_core.
//
//  port group   dir  payload                                    handshake
//  i_t*         in   tuser: kind; tdata: tick and reply fields  i_tvalid / o_tready
//  o_t*         out  tdata: state, pulses, unix time            o_tvalid / i_tready
//  i_cfg_*      in   register index, 16-bit data                i_cfg_valid / o_cfg_ready
//
// One word per cycle sustained while i_tready is high; an accepted word waits in the
// input register, its result is computed from it and loaded into the result register
// once that is free. The input register frees as the result register loads;
// while a result is held the input register takes one more word, then intake stops
// until the result leaves. Synchronous reset clears all valid flags, the client state
// and returns the configuration registers to their defaults.
// Configuration writes are always accepted.
`default_nettype none

module sntp_sync_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_tvalid,
    output logic             o_tready,
    // bits from 0 up: network_ready, rtc_write_ok, start_ok, rtc_synchronized,
    // reply_present, source_port[16], reply_length[16], header_flags[8],
    // stratum[8], transmit_seconds[32], zero fill[3]
    input  wire logic [87:0] i_tdata,
    // bits from 0 up: mode[2]
    input  wire logic [1:0]  i_tuser,
    // result stream
    output logic             o_tvalid,
    input  wire logic        i_tready,
    // bits from 0 up: sync_state[2], start_request, set_time, unix_time[32],
    // report_time, network_wait_notice, failure_notice, synced_notice
    output logic [39:0]      o_tdata,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    sntp_pkg::t_item   r_in;
    logic              r_in_vld;
    sntp_pkg::t_result r_out;
    logic              r_out_vld;

    sntp_pkg::t_item   w_item;
    sntp_pkg::t_cfg    w_cfg;
    sntp_pkg::t_reply  w_reply;
    sntp_pkg::t_result w_res;
    logic              w_adv;

    // Unpack the incoming word
    assign w_item.mode             = i_tuser;
    assign w_item.network_ready    = i_tdata[0];
    assign w_item.rtc_write_ok     = i_tdata[1];
    assign w_item.start_ok         = i_tdata[2];
    assign w_item.rtc_synchronized = i_tdata[3];
    assign w_item.reply_present    = i_tdata[4];
    assign w_item.source_port      = i_tdata[20:5];
    assign w_item.reply_length     = i_tdata[36:21];
    assign w_item.header_flags     = i_tdata[44:37];
    assign w_item.stratum          = i_tdata[52:45];
    assign w_item.transmit_seconds = i_tdata[84:53];

    // Word moves from input to result register when the result slot is free
    assign w_adv    = r_in_vld && (!r_out_vld || i_tready);
    assign o_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_tready) begin
            r_in_vld <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_in <= w_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_cfg_ready = 1'b1;

    sntp_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_index),
        .i_wr_data (i_cfg_data),
        .o_cfg     (w_cfg)
    );

    sntp_reply_check u_chk (
        .i_item        (r_in),
        .i_server_port (w_cfg.server_port),
        .o_reply       (w_reply)
    );

    sntp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in),
        .i_reply  (w_reply),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // Pack the result word
    assign o_tvalid = r_out_vld;
    assign o_tdata  = {r_out.synced_notice, r_out.failure_notice,
                       r_out.network_wait_notice, r_out.report_time,
                       r_out.unix_time, r_out.set_time, r_out.start_request,
                       r_out.sync_state};

endmodule

`default_nettype wire

// File: sv/sntp_cfg_regs.sv
// Configuration register file of the time client controller.
// Depends on sntp_pkg for register indexes and the t_cfg bundle.
`default_nettype none

module sntp_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [sntp_pkg::IDX_W-1:0] i_wr_idx,
    input  wire logic [sntp_pkg::REG_W-1:0] i_wr_data,
    output sntp_pkg::t_cfg                  o_cfg
);

    sntp_pkg::t_cfg r_cfg;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_interval  <= 16'd60;
            r_cfg.resync_interval <= 16'd3600;
            r_cfg.request_timeout <= 16'd10;
            r_cfg.report_interval <= 16'd60;
            r_cfg.server_port     <= 16'd123;
        end else if (i_wr_en) begin
            case (sntp_pkg::t_reg_idx'(i_wr_idx))
                sntp_pkg::REG_RETRY:   r_cfg.retry_interval  <= i_wr_data;
                sntp_pkg::REG_RESYNC:  r_cfg.resync_interval <= i_wr_data;
                sntp_pkg::REG_TIMEOUT: r_cfg.request_timeout <= i_wr_data;
                sntp_pkg::REG_REPORT:  r_cfg.report_interval <= i_wr_data;
                sntp_pkg::REG_PORT:    r_cfg.server_port     <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/sntp_reply_check.sv
// Reply validation: header, port, length and timestamp checks, epoch shift.
// Depends on sntp_pkg for the item and reply types and protocol constants.
`default_nettype none

module sntp_reply_check (
    input  sntp_pkg::t_item                 i_item,
    input  wire logic [sntp_pkg::REG_W-1:0] i_server_port,
    output sntp_pkg::t_reply                o_reply
);

    logic w_hdr_ok;
    logic w_pkt_ok;
    logic w_time_ok;

    // Leap indicator, mode and stratum range
    assign w_hdr_ok = (i_item.header_flags[7:6] != sntp_pkg::LEAP_ALARM)
                   && (i_item.header_flags[2:0] == sntp_pkg::NTP_MODE_SERVER)
                   && (i_item.stratum != 8'd0)
                   && (i_item.stratum <= sntp_pkg::MAX_STRATUM);

    assign w_pkt_ok  = i_item.reply_present
                    && (i_item.source_port == i_server_port)
                    && (i_item.reply_length >= sntp_pkg::MIN_LENGTH);

    // Timestamp must lie after the 1970 epoch
    assign w_time_ok = i_item.transmit_seconds > sntp_pkg::EPOCH_OFFSET;

    assign o_reply.ok        = w_hdr_ok && w_pkt_ok && w_time_ok;
    assign o_reply.unix_time = i_item.transmit_seconds - sntp_pkg::EPOCH_OFFSET;

endmodule

`default_nettype wire

// File: sv/sntp_core.sv
// Sync state machine, countdown, timeout and report counters of the client.
// Depends on sntp_pkg; takes the reply check outcome from sntp_reply_check.
`default_nettype none

module sntp_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  sntp_pkg::t_item  i_item,
    input  sntp_pkg::t_reply i_reply,
    input  sntp_pkg::t_cfg   i_cfg,
    output sntp_pkg::t_result o_result
);

    localparam int W = sntp_pkg::CNT_W;

    sntp_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_rx_time, n_rx_time;
    logic [W-1:0]     r_retry, n_retry;
    logic [W-1:0]     r_req, n_req;
    logic [W-1:0]     r_rep, n_rep;
    logic             r_wait_noted, n_wait_noted;

    sntp_pkg::t_result w_res;

    // State registers, updated once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sntp_pkg::PH_IDLE;
            r_rx_time    <= '0;
            r_retry      <= '0;
            r_req        <= '0;
            r_rep        <= sntp_pkg::clip_cnt(16'd60);
            r_wait_noted <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_rx_time    <= n_rx_time;
            r_retry      <= n_retry;
            r_req        <= n_req;
            r_rep        <= n_rep;
            r_wait_noted <= n_wait_noted;
        end
    end

    // Next state and result for one word
    always_comb begin
        n_phase      = r_phase;
        n_rx_time    = r_rx_time;
        n_retry      = r_retry;
        n_req        = r_req;
        n_rep        = r_rep;
        n_wait_noted = r_wait_noted;
        w_res        = '0;

        case (sntp_pkg::t_mode'(i_item.mode))
            sntp_pkg::MODE_TICK: begin
                if (!i_item.network_ready) begin
                    if (!r_wait_noted) begin
                        w_res.network_wait_notice = 1'b1;
                        n_wait_noted = 1'b1;
                    end
                end else begin
                    n_wait_noted = 1'b0;
                    // write a received time into the clock
                    if (r_phase == sntp_pkg::PH_RECEIVED && r_rx_time != 32'd0) begin
                        w_res.set_time  = 1'b1;
                        w_res.unix_time = r_rx_time;
                        n_rx_time = '0;
                        if (i_item.rtc_write_ok) begin
                            w_res.synced_notice = 1'b1;
                            n_phase = sntp_pkg::PH_IDLE;
                            n_retry = sntp_pkg::clip_cnt(i_cfg.resync_interval);
                            n_req   = '0;
                            n_rep   = sntp_pkg::clip_cnt(i_cfg.report_interval);
                        end else begin
                            n_phase = sntp_pkg::PH_FAILED;
                        end
                    end
                    // failure handling starts the retry wait
                    if (n_phase == sntp_pkg::PH_FAILED) begin
                        w_res.failure_notice = 1'b1;
                        n_phase = sntp_pkg::PH_IDLE;
                        n_retry = sntp_pkg::clip_cnt(i_cfg.retry_interval);
                        n_req   = '0;
                    end
                    // launch a request or count down
                    if (n_retry == '0 && n_phase == sntp_pkg::PH_IDLE) begin
                        w_res.start_request = 1'b1;
                        n_phase = i_item.start_ok ? sntp_pkg::PH_PENDING
                                                  : sntp_pkg::PH_FAILED;
                        n_req   = '0;
                    end else if (n_retry != '0) begin
                        n_retry = n_retry - W'(1);
                    end
                    // pending timeout
                    if (n_phase == sntp_pkg::PH_PENDING) begin
                        n_req = sntp_pkg::inc_sat(n_req);
                        if (n_req >= sntp_pkg::clip_cnt(i_cfg.request_timeout)) begin
                            n_phase = sntp_pkg::PH_FAILED;
                        end
                    end
                end
                // periodic report
                if (i_item.rtc_synchronized) begin
                    if (n_rep >= sntp_pkg::clip_cnt(i_cfg.report_interval)) begin
                        w_res.report_time = 1'b1;
                        n_rep = '0;
                    end
                    n_rep = sntp_pkg::inc_sat(n_rep);
                end
            end
            sntp_pkg::MODE_REPLY: begin
                if (i_reply.ok) begin
                    n_rx_time = i_reply.unix_time;
                    n_phase   = sntp_pkg::PH_RECEIVED;
                end else begin
                    n_phase   = sntp_pkg::PH_FAILED;
                end
            end
            sntp_pkg::MODE_FAIL: begin
                n_phase = sntp_pkg::PH_FAILED;
            end
            default: ;
        endcase

        w_res.sync_state = n_phase;
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

// File: sv/sntp_checker.sv
// Port-level checks for the time client controller, bound to its top level.
// Depends on assert_macros.svh and the port list of sntp_sync_controller.
`default_nettype none
`include "assert_macros.svh"

module sntp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_tvalid,
    input wire logic        i_tready,
    input wire logic [39:0] o_tdata
);

    // A held result word must not change
    `CHK_ASSERT(a_out_hold, (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata)), "result changed while stalled")

    // Time field is zero unless a clock write is signaled
    `CHK_IMPLY(a_time_zero, o_tvalid && !o_tdata[3], o_tdata[35:4] == 32'd0, "unix_time set without set_time")

    // Success only comes with a clock write and never with a failure
    `CHK_IMPLY(a_sync_set, o_tvalid && o_tdata[39], o_tdata[3] && !o_tdata[38], "synced without write or with failure")

    // A rejected clock write is handled as a failure in the same word
    `CHK_IMPLY(a_write_fail, o_tvalid && o_tdata[3] && !o_tdata[39], o_tdata[38], "failed write not handled")

    // A launched request leaves the machine pending or failed
    `CHK_IMPLY(a_start_state, o_tvalid && o_tdata[2], o_tdata[0], "request start with idle or received state")

endmodule

bind sntp_sync_controller sntp_checker u_sntp_checker (.*);

`default_nettype wire

// File: verif/sntp_sync_checker.sv
// Checker for the time client controller: watches the input, result and register write channels.
// Predicts each result from the accepted input words. Depends on sntp_pkg.
`timescale 1ns / 100ps

module sntp_sync_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream as seen at the block
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    // result stream as seen at the block
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    // register writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // status for the top
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_result_count
);
    import sntp_pkg::*;

    localparam int SHOW_LIMIT = 10;

    // register values after reset
    localparam t_cfg CFG_AT_RESET = '{
        retry_interval:  16'd60,
        resync_interval: 16'd3600,
        request_timeout: 16'd10,
        report_interval: 16'd60,
        server_port:     16'd123
    };

    // predictor state
    t_cfg             regs;
    t_phase           phase;
    logic [31:0]      held_time;
    logic [CNT_W-1:0] retry_left;
    logic [CNT_W-1:0] pending_secs;
    logic [CNT_W-1:0] report_age;
    logic             wait_seen;

    t_result awaited_results[$];
    int      fails;
    int      results;

    // register value as a counter value, limited to the counter range
    function automatic logic [CNT_W-1:0] to_counter(input logic [15:0] v);
        if (32'(v) > 32'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return CNT_W'(v);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_item input_fields(input logic [87:0] d, input logic [1:0] u);
        t_item w;
        w.mode             = u;
        w.network_ready    = d[0];
        w.rtc_write_ok     = d[1];
        w.start_ok         = d[2];
        w.rtc_synchronized = d[3];
        w.reply_present    = d[4];
        w.source_port      = d[20:5];
        w.reply_length     = d[36:21];
        w.header_flags     = d[44:37];
        w.stratum          = d[52:45];
        w.transmit_seconds = d[84:53];
        return w;
    endfunction

    function automatic t_result result_fields(input logic [39:0] d);
        t_result r;
        r.sync_state          = d[1:0];
        r.start_request       = d[2];
        r.set_time            = d[3];
        r.unix_time           = d[35:4];
        r.report_time         = d[36];
        r.network_wait_notice = d[37];
        r.failure_notice      = d[38];
        r.synced_notice       = d[39];
        return r;
    endfunction

    task automatic clear_client_state();
        regs         = CFG_AT_RESET;
        phase        = PH_IDLE;
        held_time    = '0;
        retry_left   = '0;
        pending_secs = '0;
        report_age   = to_counter(CFG_AT_RESET.report_interval);
        wait_seen    = 1'b0;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] v);
        case (t_reg_idx'(idx))
            REG_RETRY:   regs.retry_interval  = v;
            REG_RESYNC:  regs.resync_interval = v;
            REG_TIMEOUT: regs.request_timeout = v;
            REG_REPORT:  regs.report_interval = v;
            REG_PORT:    regs.server_port     = v;
            default: ;
        endcase
    endtask

    // One event of the client: updates the state and returns the pulses it causes
    task automatic advance_client_state(input t_item w, output t_result r);
        logic bad;
        r = '0;
        case (w.mode)
            MODE_TICK: begin
                if (!w.network_ready) begin
                    // notice only once per outage
                    if (!wait_seen) begin
                        r.network_wait_notice = 1'b1;
                        wait_seen = 1'b1;
                    end
                end else begin
                    wait_seen = 1'b0;
                    // write a received time into the clock
                    if (phase == PH_RECEIVED && held_time != 32'd0) begin
                        r.set_time  = 1'b1;
                        r.unix_time = held_time;
                        held_time   = '0;
                        if (w.rtc_write_ok) begin
                            r.synced_notice = 1'b1;
                            phase        = PH_IDLE;
                            retry_left   = to_counter(regs.resync_interval);
                            pending_secs = '0;
                            report_age   = to_counter(regs.report_interval);
                        end else begin
                            phase = PH_FAILED;
                        end
                    end
                    // failure: start the retry wait
                    if (phase == PH_FAILED) begin
                        r.failure_notice = 1'b1;
                        phase        = PH_IDLE;
                        retry_left   = to_counter(regs.retry_interval);
                        pending_secs = '0;
                    end
                    // new request or countdown
                    if (retry_left == '0 && phase == PH_IDLE) begin
                        r.start_request = 1'b1;
                        phase        = w.start_ok ? PH_PENDING : PH_FAILED;
                        pending_secs = '0;
                    end else if (retry_left != '0) begin
                        retry_left = retry_left - 1'b1;
                    end
                    // request timeout
                    if (phase == PH_PENDING) begin
                        pending_secs = bump(pending_secs);
                        if (pending_secs >= to_counter(regs.request_timeout)) begin
                            phase = PH_FAILED;
                        end
                    end
                end
                // periodic report while the clock is synchronized
                if (w.rtc_synchronized) begin
                    if (report_age >= to_counter(regs.report_interval)) begin
                        r.report_time = 1'b1;
                        report_age    = '0;
                    end
                    report_age = bump(report_age);
                end
            end
            MODE_REPLY: begin
                bad = !w.reply_present || w.source_port != regs.server_port ||
                      w.reply_length < MIN_LENGTH ||
                      w.header_flags[7:6] == LEAP_ALARM ||
                      w.header_flags[2:0] != NTP_MODE_SERVER ||
                      w.stratum == 8'd0 || w.stratum > MAX_STRATUM ||
                      w.transmit_seconds <= EPOCH_OFFSET;
                if (bad) begin
                    phase = PH_FAILED;
                end else begin
                    held_time = w.transmit_seconds - EPOCH_OFFSET;
                    phase     = PH_RECEIVED;
                end
            end
            MODE_FAIL: phase = PH_FAILED;
            default: ;
        endcase
        r.sync_state = phase;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= SHOW_LIMIT) begin
                $display("result %0d, %s: expected %0h, got %0h", results, name, want, got);
            end
        end
    endtask

    // Results are matched first: a result leaving at an edge is never for
    // the word accepted at that same edge.
    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_client_state();
            awaited_results.delete();
            fails   = 0;
            results = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = result_fields(i_m_tdata);
                results++;
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= SHOW_LIMIT) begin
                        $display("result %0d arrived with none expected: %h",
                                 results, i_m_tdata);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    check_field("sync_state", 32'(want.sync_state), 32'(got.sync_state));
                    check_field("start_request", 32'(want.start_request),
                                32'(got.start_request));
                    check_field("set_time", 32'(want.set_time), 32'(got.set_time));
                    check_field("unix_time", want.unix_time, got.unix_time);
                    check_field("report_time", 32'(want.report_time), 32'(got.report_time));
                    check_field("network_wait_notice", 32'(want.network_wait_notice),
                                32'(got.network_wait_notice));
                    check_field("failure_notice", 32'(want.failure_notice),
                                32'(got.failure_notice));
                    check_field("synced_notice", 32'(want.synced_notice),
                                32'(got.synced_notice));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_client_state(input_fields(i_s_tdata, i_s_tuser), want);
                awaited_results.push_back(want);
            end
        end
        o_fail_count   <= fails;
        o_outstanding  <= awaited_results.size();
        o_result_count <= results;
    end

endmodule

// File: verif/sntp_sync_controller_tb.sv
// Testbench top for the time client controller: clock, reset, stimulus and verdict.
// Depends on sntp_pkg, the block sntp_sync_controller and the checker sntp_sync_checker.
`timescale 1ns / 100ps

module sntp_sync_controller_tb;
    import sntp_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;  // fourth kind, ignored by the block
    localparam int QUIET_LIMIT = 4000;          // cycles without any handshake
    localparam int LONG_HOLD   = 300;           // receiver hold-off stretch
    localparam int END_SLACK   = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_tvalid;
    logic        o_tready;
    logic [87:0] i_tdata;
    logic [1:0]  i_tuser;
    logic        o_tvalid;
    logic        i_tready;
    logic [39:0] o_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int fail_count;
    int outstanding;
    int result_count;

    // idle control shared with the receiver process
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_go;

    logic [15:0] cur_port;
    int          words_sent;
    int          settings_used;

    sntp_sync_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_tvalid),
        .o_tready    (o_tready),
        .i_tdata     (i_tdata),
        .i_tuser     (i_tuser),
        .o_tvalid    (o_tvalid),
        .i_tready    (i_tready),
        .o_tdata     (o_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sntp_sync_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_tvalid),
        .i_s_tready     (o_tready),
        .i_s_tdata      (i_tdata),
        .i_s_tuser      (i_tuser),
        .i_m_tvalid     (o_tvalid),
        .i_m_tready     (i_tready),
        .i_m_tdata      (o_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Result side: random stalls, plus one long hold-off when asked
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        i_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_tready <= 1'b0;
            end else begin
                i_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run when nothing moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_tvalid && o_tready) || (o_tvalid && i_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // fields from bit 0 up, as the block's port list gives them
    function automatic logic [87:0] packed_data(input t_item w);
        return {3'b000, w.transmit_seconds, w.stratum, w.header_flags, w.reply_length,
                w.source_port, w.reply_present, w.rtc_synchronized, w.start_ok,
                w.rtc_write_ok, w.network_ready};
    endfunction

    function automatic t_item tick_word(input logic net, input logic wr_ok,
                                        input logic st_ok, input logic rtc_sync);
        t_item w;
        w                  = '0;
        w.mode             = MODE_TICK;
        w.network_ready    = net;
        w.rtc_write_ok     = wr_ok;
        w.start_ok         = st_ok;
        w.rtc_synchronized = rtc_sync;
        return w;
    endfunction

    // well-formed reply with the smallest length, stratum and time
    function automatic t_item good_reply();
        t_item w;
        w                  = '0;
        w.mode             = MODE_REPLY;
        w.reply_present    = 1'b1;
        w.source_port      = cur_port;
        w.reply_length     = MIN_LENGTH;
        w.header_flags     = {2'b00, 3'd4, NTP_MODE_SERVER};
        w.stratum          = 8'd1;
        w.transmit_seconds = EPOCH_OFFSET + 32'd1;
        return w;
    endfunction

    function automatic t_item random_word();
        t_item       w;
        int unsigned pick;
        w.network_ready    = ($urandom_range(99) < 85);
        w.rtc_write_ok     = ($urandom_range(99) < 80);
        w.start_ok         = ($urandom_range(99) < 85);
        w.rtc_synchronized = ($urandom_range(99) < 70);
        w.reply_present    = $urandom_range(1);
        w.source_port      = 16'($urandom);
        w.reply_length     = 16'($urandom);
        w.header_flags     = 8'($urandom);
        w.stratum          = 8'($urandom);
        w.transmit_seconds = $urandom;
        pick = $urandom_range(99);
        if (pick < 55) begin
            w.mode = MODE_TICK;
        end else if (pick < 85) begin
            w.mode             = MODE_REPLY;
            w.reply_present    = 1'b1;
            w.source_port      = cur_port;
            w.reply_length     = 16'($urandom_range(16'hFFFF, MIN_LENGTH));
            w.header_flags     = {2'($urandom_range(2)), 3'($urandom), NTP_MODE_SERVER};
            w.stratum          = 8'($urandom_range(MAX_STRATUM, 1));
            w.transmit_seconds = $urandom_range(32'hFFFF_FFFF, EPOCH_OFFSET + 32'd1);
            // a share of replies carries one defect
            if ($urandom_range(99) < 30) begin
                case ($urandom_range(7))
                    0: w.reply_present = 1'b0;
                    1: w.source_port = cur_port + 16'($urandom_range(16'hFFFF, 1));
                    2: w.reply_length = 16'($urandom_range(MIN_LENGTH - 1));
                    3: w.header_flags[7:6] = LEAP_ALARM;
                    4: w.header_flags[2:0] = NTP_MODE_SERVER ^ 3'($urandom_range(7, 1));
                    5: w.stratum = 8'd0;
                    6: w.stratum = 8'($urandom_range(255, MAX_STRATUM + 1));
                    default: w.transmit_seconds = $urandom_range(EPOCH_OFFSET);
                endcase
            end
        end else if (pick < 95) begin
            w.mode = MODE_FAIL;
        end else begin
            w.mode = KIND_UNUSED;
        end
        return w;
    endfunction

    task automatic offer_word(input t_item w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= packed_data(w);
        i_tuser  <= w.mode;
        @(posedge i_clk);
        while (!o_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // stop sending and wait for every awaited result
    task automatic drain();
        i_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(REG_RETRY, c.retry_interval);
        write_reg(REG_RESYNC, c.resync_interval);
        write_reg(REG_TIMEOUT, c.request_timeout);
        write_reg(REG_REPORT, c.report_interval);
        write_reg(REG_PORT, c.server_port);
        i_cfg_valid <= 1'b0;
        cur_port = c.server_port;
        settings_used++;
    endtask

    // one random stretch under one register setting and one idle pattern
    task automatic run_phase(input t_cfg c, input int snd, input int rcv, input int count,
                             input int hold_at, input int pause_at);
        drain();
        apply_settings(c);
        send_idle_pct = snd;
        recv_stall_pct <= rcv;
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) begin
                hold_go <= 1'b1;
            end
            if (k == pause_at) begin
                drain();
            end
            offer_word(random_word());
        end
    endtask

    function automatic t_cfg small_random_cfg();
        t_cfg c;
        c.retry_interval  = 16'($urandom_range(8, 1));
        c.resync_interval = 16'($urandom_range(8, 1));
        c.request_timeout = 16'($urandom_range(8, 1));
        c.report_interval = 16'($urandom_range(8, 1));
        c.server_port     = 16'($urandom);
        return c;
    endfunction

    initial begin : stimulus
        t_item w;
        t_cfg  c;
        i_rst_n        <= 1'b0;
        i_tvalid       <= 1'b0;
        i_tdata        <= '0;
        i_tuser        <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        recv_stall_pct <= 0;
        hold_go        <= 1'b0;
        send_idle_pct = 0;
        cur_port      = 16'd123;
        words_sent    = 0;
        settings_used = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short intervals so the directed words walk the whole state machine
        apply_settings('{retry_interval: 16'd2, resync_interval: 16'd3,
                         request_timeout: 16'd2, report_interval: 16'd1,
                         server_port: 16'd123});

        // network outage noticed once
        offer_word(tick_word(1'b0, 1'b1, 1'b1, 1'b1));
        offer_word(tick_word(1'b0, 1'b1, 1'b1, 1'b1));
        // request, smallest valid reply, clock write
        offer_word(tick_word(1'b1, 1'b1, 1'b1, 1'b0));
        offer_word(good_reply());
        offer_word(tick_word(1'b1, 1'b1, 1'b1, 1'b1));
        // largest valid reply while no request pending, then a refused write
        w = good_reply();
        w.reply_length     = 16'hFFFF;
        w.header_flags     = {2'b10, 3'd4, NTP_MODE_SERVER};
        w.stratum          = MAX_STRATUM;
        w.transmit_seconds = 32'hFFFF_FFFF;
        offer_word(w);
        offer_word(tick_word(1'b1, 1'b0, 1'b1, 1'b1));
        // each way a reply can be rejected
        w = good_reply();
        w.reply_present = 1'b0;
        offer_word(w);
        w = good_reply();
        w.source_port = cur_port + 16'd1;
        offer_word(w);
        w = good_reply();
        w.reply_length = MIN_LENGTH - 16'd1;
        offer_word(w);
        w = good_reply();
        w.header_flags[7:6] = LEAP_ALARM;
        offer_word(w);
        w = good_reply();
        w.header_flags[2:0] = 3'd3;
        offer_word(w);
        w = good_reply();
        w.stratum = 8'd0;
        offer_word(w);
        w = good_reply();
        w.stratum = MAX_STRATUM + 8'd1;
        offer_word(w);
        w = good_reply();
        w.transmit_seconds = EPOCH_OFFSET;
        offer_word(w);
        // failure event and the unused kind
        w = '0;
        w.mode = MODE_FAIL;
        offer_word(w);
        w = '1;
        w.mode = KIND_UNUSED;
        offer_word(w);
        // failure handled, countdown, launch refused, then a request timing out
        offer_word(tick_word(1'b1, 1'b1, 1'b1, 1'b1));
        offer_word(tick_word(1'b1, 1'b1, 1'b1, 1'b1));
        offer_word(tick_word(1'b1, 1'b1, 1'b0, 1'b1));
        for (int k = 0; k < 5; k++) begin
            offer_word(tick_word(1'b1, 1'b1, 1'b1, 1'b0));
        end

        // random stretches: no idling, sender idle, receiver stalling, both
        run_phase('{retry_interval: 16'd3, resync_interval: 16'd5, request_timeout: 16'd4,
                    report_interval: 16'd2, server_port: 16'd123},
                  0, 0, 120, 30, -1);
        run_phase('{retry_interval: 16'd1, resync_interval: 16'd1, request_timeout: 16'd1,
                    report_interval: 16'd1, server_port: 16'd0},
                  81, 0, 100, -1, -1);
        run_phase('{retry_interval: 16'hFFFF, resync_interval: 16'hFFFF,
                    request_timeout: 16'hFFFF, report_interval: 16'hFFFF,
                    server_port: 16'hFFFF},
                  0, 81, 80, -1, -1);
        c = '0;
        c.server_port = 16'($urandom);
        run_phase(c, 13, 13, 80, -1, -1);
        run_phase(small_random_cfg(), 0, 0, 120, -1, 50);
        c.retry_interval  = 16'($urandom_range(16'hFFFF, 1));
        c.resync_interval = 16'($urandom_range(16'hFFFF, 1));
        c.request_timeout = 16'($urandom_range(16'hFFFF, 1));
        c.report_interval = 16'($urandom_range(16'hFFFF, 1));
        c.server_port     = 16'($urandom);
        run_phase(c, 0, 81, 80, -1, -1);

        drain();
        repeat (END_SLACK) @(posedge i_clk);
        $display("Sent %0d words and checked %0d results over %0d register settings,",
                 words_sent, result_count, settings_used);
        $display("with idle senders, stalled receivers and one long back-pressure stretch.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results still awaited", fail_count, outstanding);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/sntp_pkg.sv
sv/sntp_cfg_regs.sv
sv/sntp_reply_check.sv
sv/sntp_core.sv
sv/sntp_sync_controller.sv
sv/sntp_checker.sv
verif/sntp_sync_checker.sv
verif/sntp_sync_controller_tb.sv
